/* sv/tgen_pkg.sv */
// ----------------------------------------------------------------------------
// Tone generator package
// Shared constants and field layout for the square wave tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tgen_pkg;

  // Default clock and prescale settings.
  localparam int unsigned CLOCK_HZ_DEF      = 16000000;
  localparam int unsigned SLOW_PRESCALE_DEF = 8;

  // Frequency request limits in hertz.
  localparam int unsigned FREQ_MIN        = 20;
  localparam int unsigned FREQ_MAX        = 200000;
  localparam int unsigned FREQ_SLOW_LIMIT = 4000;

  // Field widths.
  localparam int unsigned FREQ_W = 18;
  localparam int unsigned CMP_W  = 16;

  // Stream data widths, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;
  localparam int unsigned M_FIELD_W = 3 + CMP_W;

  // Command codes carried in the input tuser bit.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_FREQ = 1'b1;

endpackage

`default_nettype wire

/* sv/square_wave_tone_generator_top.sv */
// ----------------------------------------------------------------------------
// Square wave tone generator
// Buzzer tone source built on a clear-on-compare timer with a bit-serial
// divider for the compare value.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel. tuser selects the command:
//   0 is one base clock tick, 1 is a frequency request with the frequency in
//   tdata. Every input item produces exactly one output item on m_axis that
//   shows the state after the item: pin level, sounding flag, compare value
//   and prescale mode. The mute register is written through the cfg channel,
//   which is always ready.
//   Ticks and stop requests are handled in idle: the block is ready again on
//   the next cycle, so ticks can stream at one item per cycle while the
//   receiver keeps taking output items. A play request runs a restoring
//   divider with one quotient bit per cycle over the NUM_W bits of CLOCK_HZ/2,
//   and the block takes no new item until its divide, apply and emit states end.
//   The output item sits in a register; the next item is accepted while it
//   waits, as long as it is taken in the same cycle the new one completes.
//   When the receiver stalls, tready drops once a finished item would have to
//   overwrite the waiting one.
//   Reset stops the timer, clears the counter, the tone and mute.
// ----------------------------------------------------------------------------
`default_nettype none

module square_wave_tone_generator_top #(
  parameter int unsigned CLOCK_HZ      = tgen_pkg::CLOCK_HZ_DEF,
  parameter int unsigned SLOW_PRESCALE = tgen_pkg::SLOW_PRESCALE_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input items
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  input  wire logic [tgen_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [17:0] freq_hz
  input  wire logic                           s_axis_tuser,  // [0] cmd
  // Output items
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] tone_out, [1] sounding, [17:2] compare_value, [18] fast_prescale
  output      logic [tgen_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // Configuration
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic                           cfg_data_i     // [0] mute
);

  localparam int unsigned FREQ_W   = tgen_pkg::FREQ_W;
  localparam int unsigned CMP_W    = tgen_pkg::CMP_W;
  localparam int unsigned NUM_W    = $clog2(CLOCK_HZ / 2 + 1);
  localparam int unsigned CNT_W    = $clog2(NUM_W);
  localparam int unsigned PS_W     = $clog2(SLOW_PRESCALE);
  localparam logic [NUM_W-1:0] FAST_NUMER = NUM_W'(CLOCK_HZ / 2);
  localparam logic [NUM_W-1:0] SLOW_NUMER = NUM_W'(CLOCK_HZ / 2 / SLOW_PRESCALE);
  localparam logic [PS_W-1:0]  PS_LIMIT   = PS_W'(SLOW_PRESCALE - 1);
  localparam logic [NUM_W-1:0] CMP_MAX_N  = NUM_W'({CMP_W{1'b1}});
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(NUM_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_APPLY,
    S_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [CMP_W-1:0]              count_q, count_d;
  logic [CMP_W-1:0]              top_q, top_d;
  logic [PS_W-1:0]               ps_q, ps_d;
  logic                          fast_q, fast_d;
  logic                          running_q, running_d;
  logic                          active_q, active_d;
  logic                          pin_q, pin_d;
  logic                          stop_pend_q, stop_pend_d;
  logic                          mute_q, mute_d;
  // Divider state
  logic [FREQ_W-1:0]             div_q, div_d;
  logic [FREQ_W-1:0]             rem_q, rem_d;
  logic [NUM_W-1:0]              quo_q, quo_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          fast_req_q, fast_req_d;
  // Output register
  logic                          out_valid_q, out_valid_d;
  logic [tgen_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;

  logic                          in_acc;
  logic                          slot_free;
  logic [FREQ_W-1:0]             freq;
  logic                          stop_req;
  logic [FREQ_W:0]               trial;
  logic                          trial_ge;
  logic [NUM_W-1:0]              quo_m1;
  logic [CMP_W-1:0]              new_top;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && slot_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign freq     = s_axis_tdata[FREQ_W-1:0];
  assign stop_req = mute_q || (freq < FREQ_W'(tgen_pkg::FREQ_MIN))
                    || (freq > FREQ_W'(tgen_pkg::FREQ_MAX));

  // One restoring division step: shift in the next dividend bit and subtract.
  assign trial    = {rem_q, quo_q[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, div_q};

  // Compare value from the quotient: minus one, saturating, zero stays zero.
  assign quo_m1 = quo_q - NUM_W'(1);
  always_comb begin
    if (quo_q == '0) begin
      new_top = '0;
    end else if (quo_m1 > CMP_MAX_N) begin
      new_top = {CMP_W{1'b1}};
    end else begin
      new_top = quo_m1[CMP_W-1:0];
    end
  end

  // Sequencer and timer next-state logic.
  always_comb begin
    logic step;
    logic load_out;
    step        = 1'b0;
    load_out    = 1'b0;
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    ps_d        = ps_q;
    fast_d      = fast_q;
    running_d   = running_q;
    active_d    = active_q;
    pin_d       = pin_q;
    stop_pend_d = stop_pend_q;
    mute_d      = mute_q;
    div_d       = div_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    fast_req_d  = fast_req_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    if (cfg_valid_i) begin
      mute_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == tgen_pkg::CMD_TICK) begin
            // Tick: while running, advance the prescaler (bypassed in fast mode), then the counter.
            load_out = 1'b1;
            if (running_q) begin
              if (fast_q) begin
                step = 1'b1;
              end else if (ps_q >= PS_LIMIT) begin
                ps_d = '0;
                step = 1'b1;
              end else begin
                ps_d = ps_q + PS_W'(1);
              end
              if (step) begin
                if (count_q >= top_q) begin
                  count_d = '0;
                end else begin
                  count_d = count_q + CMP_W'(1);
                end
                if (count_d == '0) begin
                  if (stop_pend_q) begin
                    active_d    = 1'b0;
                    pin_d       = 1'b0;
                    stop_pend_d = 1'b0;
                  end else if (active_q) begin
                    pin_d = !pin_q;
                  end
                end
              end
            end
          end else if (stop_req) begin
            // Stop: at once when the counter sits at zero, else at next wrap.
            load_out = 1'b1;
            if (active_q) begin
              if (count_q == '0) begin
                active_d    = 1'b0;
                pin_d       = 1'b0;
                stop_pend_d = 1'b0;
              end else begin
                stop_pend_d = 1'b1;
              end
            end
          end else begin
            // Play: start the divider on the selected numerator.
            fast_req_d = freq > FREQ_W'(tgen_pkg::FREQ_SLOW_LIMIT);
            quo_d      = fast_req_d ? FAST_NUMER : SLOW_NUMER;
            div_d      = freq;
            rem_d      = '0;
            cnt_d      = CNT_LAST;
            state_d    = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_d = trial_ge ? FREQ_W'(trial - {1'b0, div_q}) : trial[FREQ_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], trial_ge};
        if (cnt_q == '0) begin
          state_d = S_APPLY;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_APPLY: begin
        // Load the new compare value, starting the timer if it was idle.
        stop_pend_d = 1'b0;
        if (!active_q) begin
          count_d = '0;
          ps_d    = '0;
          pin_d   = 1'b0;
        end
        running_d = 1'b1;
        active_d  = 1'b1;
        fast_d    = fast_req_q;
        if (count_d >= new_top) begin
          count_d = '0;
        end
        top_d   = new_top;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Snapshot of the state after the item.
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {(tgen_pkg::M_TDATA_W - tgen_pkg::M_FIELD_W)'(0),
                     fast_d, top_d, active_d, active_d && pin_d};
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      ps_q        <= '0;
      fast_q      <= 1'b0;
      running_q   <= 1'b0;
      active_q    <= 1'b0;
      pin_q       <= 1'b0;
      stop_pend_q <= 1'b0;
      mute_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      ps_q        <= ps_d;
      fast_q      <= fast_d;
      running_q   <= running_d;
      active_q    <= active_d;
      pin_q       <= pin_d;
      stop_pend_q <= stop_pend_d;
      mute_q      <= mute_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Divider and output payload registers.
  always_ff @(posedge clk_i) begin
    div_q      <= div_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    fast_req_q <= fast_req_d;
    out_data_q <= out_data_d;
  end

  // A pending stop only exists while a tone is sounding.
  a_stop_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_pend_q |-> active_q)
    else $error("stop pending without an active tone");

  // A tone never sounds on a stopped timer.
  a_active_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> running_q)
    else $error("active tone with the timer stopped");

  // The pin is low whenever the tone is not active.
  a_pin_low_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !pin_q)
    else $error("pin high without an active tone");

  // The counter never runs past the compare value.
  a_count_le_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= top_q)
    else $error("counter past the compare value");

  // The prescaler stays within its divide range.
  a_ps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ps_q <= PS_LIMIT)
    else $error("prescaler out of range");

endmodule

`default_nettype wire
